/* sv/ttrc_pkg.sv */
`timescale 1ns / 1ps

package ttrc_pkg;

    localparam logic [16:0] MODULUS      = 17'd65535;
    localparam logic [16:0] WRAP_BASE    = 17'h10000;
    localparam logic [15:0] FIRST_OFFSET = 16'd7;
    localparam logic [15:0] TERM_RESET   = 16'd1;
    localparam logic [7:0]  COEF_A       = 8'd17;
    localparam logic [7:0]  COEF_B       = 8'd31;
    localparam logic [7:0]  POS_FIRST    = 8'd1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_beat;

    typedef struct packed {
        logic emit;
        logic awaiting_first;
    } t_core_stat;

    // fold a 25-bit magnitude modulo 65535
    function automatic logic [15:0] fold_mod(input logic [24:0] mag);
        logic [16:0] s;
        logic [16:0] r;
        s = {8'b0, mag[24:16]} + {1'b0, mag[15:0]};
        r = (s >= MODULUS) ? (s - MODULUS) : s;
        return r[15:0];
    endfunction

endpackage

/* sv/ttrc_in_stage.sv */
`timescale 1ns / 1ps

module ttrc_in_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  ttrc_pkg::t_beat       i_beat,
    output logic                  o_valid,
    output ttrc_pkg::t_beat       o_beat,
    input  logic                  i_take
);

    logic            r_valid;
    ttrc_pkg::t_beat r_beat;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_beat  = r_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_beat <= i_beat;
        end
    end

endmodule

/* sv/ttrc_core.sv */
`timescale 1ns / 1ps

module ttrc_core (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_take,
    input  ttrc_pkg::t_beat        i_beat,
    output logic [15:0]            o_checksum,
    output ttrc_pkg::t_core_stat   o_stat
);

    logic [15:0] r_older;
    logic [15:0] r_newer;
    logic [7:0]  r_pos;
    logic        r_awaiting;

    logic [15:0] n_older;
    logic [15:0] n_newer;
    logic [7:0]  n_pos;

    logic [7:0]  coef_a;
    logic [7:0]  coef_b;
    logic [8:0]  factor_a;
    logic [24:0] plus;
    logic [24:0] minus;
    logic        neg;
    logic [24:0] mag;
    logic [15:0] rem;
    logic [16:0] wrap_val;
    logic [15:0] term;

    always_comb begin
        coef_a   = r_pos * ttrc_pkg::COEF_A;
        coef_b   = r_pos * ttrc_pkg::COEF_B;
        factor_a = {1'b0, i_beat.data_byte} + {1'b0, coef_a};
        plus     = {16'b0, factor_a} * {9'b0, r_newer};
        minus    = {17'b0, coef_b} * {9'b0, r_older};
        neg      = plus < minus;
        mag      = neg ? (minus - plus) : (plus - minus);
        rem      = ttrc_pkg::fold_mod(mag);
        wrap_val = ttrc_pkg::WRAP_BASE - {1'b0, rem};
        // negative difference: result is (1 - rem) mod 65535
        if (!neg) begin
            term = rem;
        end else if (rem == 16'd0) begin
            term = 16'd1;
        end else if (rem == 16'd1) begin
            term = 16'd0;
        end else begin
            term = wrap_val[15:0];
        end

        if (r_awaiting) begin
            n_older = ttrc_pkg::TERM_RESET;
            n_newer = {8'b0, i_beat.data_byte} + ttrc_pkg::FIRST_OFFSET;
            n_pos   = ttrc_pkg::POS_FIRST;
        end else begin
            n_older = r_newer;
            n_newer = term;
            n_pos   = r_pos + 8'd1;
        end
    end

    assign o_checksum            = n_newer;
    assign o_stat.emit           = i_take && i_beat.last_byte;
    assign o_stat.awaiting_first = r_awaiting;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_older    <= ttrc_pkg::TERM_RESET;
            r_newer    <= ttrc_pkg::TERM_RESET;
            r_pos      <= 8'd0;
            r_awaiting <= 1'b1;
        end else if (i_take) begin
            if (i_beat.last_byte) begin
                r_older    <= ttrc_pkg::TERM_RESET;
                r_newer    <= ttrc_pkg::TERM_RESET;
                r_pos      <= 8'd0;
                r_awaiting <= 1'b1;
            end else begin
                r_older    <= n_older;
                r_newer    <= n_newer;
                r_pos      <= n_pos;
                r_awaiting <= 1'b0;
            end
        end
    end

endmodule

/* sv/ttrc_out_stage.sv */
`timescale 1ns / 1ps

module ttrc_out_stage (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  logic [15:0] i_data,
    output logic        o_free,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_data
);

    logic        r_valid;
    logic [15:0] r_data;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

endmodule

/* sv/three_term_recurrence_checksum_top.sv */
`timescale 1ns / 1ps
// Channel   Dir  Beat                          Accepted when
// s_axis    in   data_byte (tdata), last_byte  i_s_axis_tvalid && o_s_axis_tready
//                (tlast)
// m_axis    out  checksum (tdata)              o_m_axis_tvalid && i_m_axis_tready
//
// One byte per cycle while s_axis is not held; a byte is registered in the input
// stage and updates the recurrence at the edge that takes it from there, through
// the two small multiplies and the mod-65535 fold in the core. The checksum is
// loaded into the output register at that same edge. Reset is synchronous, active
// low, and returns the recurrence to its start. A stalled m_axis only holds s_axis
// when the waiting byte is a last byte and the output register is full.

module three_term_recurrence_checksum_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] data_byte
    input  logic        i_s_axis_tlast,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata    // [15:0] checksum
);

    ttrc_pkg::t_beat      in_beat;
    ttrc_pkg::t_beat      held_beat;
    ttrc_pkg::t_core_stat core_stat;
    logic                 held_valid;
    logic                 out_free;
    logic                 take;
    logic [15:0]          checksum;

    assign in_beat.data_byte = i_s_axis_tdata;
    assign in_beat.last_byte = i_s_axis_tlast;
    assign take = held_valid && (!held_beat.last_byte || out_free);

    ttrc_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_beat  (in_beat),
        .o_valid (held_valid),
        .o_beat  (held_beat),
        .i_take  (take)
    );

    ttrc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (take),
        .i_beat     (held_beat),
        .o_checksum (checksum),
        .o_stat     (core_stat)
    );

    ttrc_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (core_stat.emit),
        .i_data  (checksum),
        .o_free  (out_free),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata)
    );

    a_sum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata != 16'hFFFF)
        else $error("checksum out of range");

    a_emit_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_stat.emit |=> core_stat.awaiting_first)
        else $error("packet state not cleared after last byte");

    a_emit_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_stat.emit |-> out_free)
        else $error("checksum loaded into a full output register");

    a_emit_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        core_stat.emit |=> o_m_axis_tvalid)
        else $error("checksum lost");

endmodule

/* test/tb_three_term_recurrence_checksum_top.sv */
`timescale 1ns / 1ps

module tb_three_term_recurrence_checksum_top;

    localparam int unsigned CHECKSUM_MODULUS = 65535;
    localparam int unsigned STEP_COEF_A      = 17;
    localparam int unsigned STEP_COEF_B      = 31;
    localparam int unsigned FIRST_BIAS       = 7;
    localparam int unsigned WATCHDOG_LIMIT   = 5000;
    localparam int unsigned LONG_HOLD_CYCLES = 300;
    localparam int unsigned DRAIN_TAIL       = 16;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [7:0]  i_s_axis_tdata;   // [7:0] data_byte
    logic        i_s_axis_tlast;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [15:0] o_m_axis_tdata;   // [15:0] checksum

    logic [15:0] pending_checksums[$];
    logic [15:0] oldest_checksum;

    logic [15:0] term_older;
    logic [15:0] term_newer;
    logic [7:0]  term_pos;
    logic        packet_start;

    bit          idle_enable;
    int unsigned long_hold_len;
    int unsigned error_count;
    int unsigned byte_count;
    int unsigned packet_count;
    int unsigned checksum_count;
    int unsigned wrap_count;
    int unsigned packet_len;
    int unsigned longest_packet;

    three_term_recurrence_checksum_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [15:0] next_recurrence_term(
        input  logic [7:0]  data,
        input  logic [7:0]  pos,
        input  logic [15:0] older,
        input  logic [15:0] newer,
        output bit          wrapped
    );
        int unsigned coef_a;
        int unsigned coef_b;
        int unsigned plus;
        int unsigned minus;
        coef_a  = data + ((STEP_COEF_A * pos) & 32'hFF);
        coef_b  = (STEP_COEF_B * pos) & 32'hFF;
        plus    = coef_a * newer;
        minus   = coef_b * older;
        wrapped = (plus < minus);
        if (!wrapped) begin
            return 16'((plus - minus) % CHECKSUM_MODULUS);
        end
        return 16'((CHECKSUM_MODULUS + 1 - ((minus - plus) % CHECKSUM_MODULUS))
                   % CHECKSUM_MODULUS);
    endfunction

    task automatic clear_recurrence();
        term_older   = 16'd1;
        term_newer   = 16'd1;
        term_pos     = 8'd0;
        packet_start = 1'b1;
    endtask

    task automatic absorb_byte(input logic [7:0] data, input logic last);
        bit          wrapped;
        logic [15:0] term;
        byte_count++;
        packet_len++;
        if (packet_start) begin
            term_older   = 16'd1;
            term_newer   = 16'(data + FIRST_BIAS);
            term_pos     = 8'd1;
            packet_start = 1'b0;
        end else begin
            term = next_recurrence_term(data, term_pos, term_older, term_newer, wrapped);
            if (wrapped) begin
                wrap_count++;
            end
            term_older = term_newer;
            term_newer = term;
            term_pos   = term_pos + 8'd1;
        end
        if (last) begin
            pending_checksums.push_back(term_newer);
            packet_count++;
            if (packet_len > longest_packet) begin
                longest_packet = packet_len;
            end
            packet_len = 0;
            clear_recurrence();
        end
    endtask

    task automatic send_beat(input logic [7:0] data, input logic last);
        if (idle_enable && $urandom_range(0, 7) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= 8'($urandom);
            i_s_axis_tlast  <= 1'($urandom);
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= data;
        i_s_axis_tlast  <= last;
        do @(posedge i_clk); while (!(i_s_axis_tvalid && o_s_axis_tready));
        absorb_byte(data, last);
    endtask

    task automatic send_random_packet(input int unsigned len);
        for (int unsigned i = 0; i < len; i++) begin
            send_beat(8'($urandom), i == len - 1);
        end
    endtask

    task automatic stop_sending();
        i_s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_checksums.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_single_byte_packets();
        send_beat(8'h00, 1'b1);
        send_beat(8'hFF, 1'b1);
        send_beat(8'h5A, 1'b1);
    endtask

    task automatic test_uniform_packets();
        for (int i = 0; i < 8; i++) begin
            send_beat(8'h00, i == 7);
        end
        for (int i = 0; i < 8; i++) begin
            send_beat(8'hFF, i == 7);
        end
        send_beat(8'h80, 1'b0);
        send_beat(8'h01, 1'b0);
        send_beat(8'hFE, 1'b0);
        send_beat(8'h7F, 1'b1);
    endtask

    task automatic test_position_wrap();
        send_random_packet(300);
    endtask

    task automatic test_random_packets();
        int unsigned start_bytes;
        start_bytes = byte_count;
        while (byte_count - start_bytes < 320) begin
            if ($urandom_range(0, 9) == 0) begin
                send_random_packet($urandom_range(13, 40));
            end else begin
                send_random_packet($urandom_range(1, 12));
            end
        end
    endtask

    task automatic test_output_backpressure();
        long_hold_len = LONG_HOLD_CYCLES;
        for (int i = 0; i < 30; i++) begin
            send_random_packet($urandom_range(1, 2));
        end
        stop_sending();
        wait_drained();
    endtask

    task automatic test_steady_stream();
        int unsigned start_bytes;
        idle_enable = 1'b0;
        start_bytes = byte_count;
        while (byte_count - start_bytes < 80) begin
            send_random_packet($urandom_range(1, 10));
        end
    endtask

    initial begin
        i_m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_len != 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (long_hold_len) @(posedge i_clk);
                long_hold_len = 0;
                i_m_axis_tready <= 1'b1;
            end else if (idle_enable && $urandom_range(0, 9) == 0) begin
                i_m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
                i_m_axis_tready <= 1'b1;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_checksums.size() == 0) begin
                $display("%0t: unexpected checksum beat: expected none, actual %0d",
                         $time, o_m_axis_tdata);
                error_count++;
            end else begin
                oldest_checksum = pending_checksums.pop_front();
                checksum_count++;
                if (o_m_axis_tdata !== oldest_checksum) begin
                    $display("%0t: checksum mismatch: expected %0d, actual %0d",
                             $time, oldest_checksum, o_m_axis_tdata);
                    error_count++;
                end
            end
        end
    end

    initial begin : watchdog
        int unsigned idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
    end

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = 8'd0;
        i_s_axis_tlast  = 1'b0;
        idle_enable     = 1'b1;
        long_hold_len   = 0;
        error_count     = 0;
        byte_count      = 0;
        packet_count    = 0;
        checksum_count  = 0;
        wrap_count      = 0;
        packet_len      = 0;
        longest_packet  = 0;
        clear_recurrence();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_single_byte_packets();
        test_uniform_packets();
        test_position_wrap();
        test_random_packets();
        test_output_backpressure();
        test_steady_stream();

        stop_sending();
        wait_drained();
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (pending_checksums.size() != 0) begin
            $display("%0t: %0d checksums outstanding: expected %0d, actual none",
                     $time, pending_checksums.size(), pending_checksums[0]);
            error_count++;
        end

        $display("covered %0d bytes in %0d packets (longest %0d bytes, position wrap included)",
                 byte_count, packet_count, longest_packet);
        $display("compared %0d checksums, %0d negative differences, long output stall",
                 checksum_count, wrap_count);
        if (error_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* filelist.f */
sv/ttrc_pkg.sv
sv/ttrc_in_stage.sv
sv/ttrc_core.sv
sv/ttrc_out_stage.sv
sv/three_term_recurrence_checksum_top.sv
test/tb_three_term_recurrence_checksum_top.sv
